@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

@@ rtl/core/vp8df_pkg.sv @@
package vp8df_pkg;

  localparam int unsigned DESC_MAX = 6;
  localparam logic [15:0] MAX_FRAG_RESET = 16'd1200;

  localparam logic [7:0] FLAG_X   = 8'h80;  // extension present / I / M bit
  localparam logic [7:0] PID_MASK = 8'h7F;
  localparam logic [7:0] P_BIT    = 8'h01;
  localparam logic [7:0] S_BIT    = 8'h10;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_EXT     = 3'd1,
    PH_PID_HI  = 3'd2,
    PH_PID_LO  = 3'd3,
    PH_TL0     = 3'd4,
    PH_TID     = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       unit_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        fragment_last;
    logic        unit_done;
    logic        has_picture_id;
    logic [14:0] picture_id;
    logic        key_frame;
  } out_item_t;

  // Work for one accepted item: optional descriptor replay, then optional payload byte
  typedef struct packed {
    logic [DESC_MAX-1:0][7:0] desc;
    logic [2:0]               desc_count;
    logic                     has_payload;
    logic [7:0]               payload_byte;
    logic                     payload_last;
    logic                     unit_done;
    logic                     has_picture_id;
    logic [14:0]              picture_id;
    logic                     key_frame;
  } job_t;

endpackage

@@ rtl/core/vp8_descriptor_fragmenter.sv @@
// VP8 RTP payload descriptor fragmenter. Bytes of a VP8 unit enter on in_data with a
// last-byte mark; the leading payload descriptor (up to six bytes) is parsed and held,
// and the payload leaves on out_data cut into fragments of at most max_fragment_size
// bytes (cfg_data, reset 1200), each fragment opening with a copy of the descriptor,
// S bit cleared after the first; a limit not above the descriptor length gives one
// payload byte per fragment. A unit ending inside its descriptor is passed through as
// one fragment. The final result of a unit carries unit_done with the picture ID and
// key-frame flag. An input byte is taken every cycle when it yields at most one result
// and out_ready is high; a byte that opens a fragment, and the last byte of a unit cut
// inside its descriptor, wait while the single output register replays the descriptor
// one byte per cycle unless stalled. Write the limit only while the block is idle.
module vp8_descriptor_fragmenter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vp8df_pkg::in_item_t  in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vp8df_pkg::out_item_t out_data
);

  logic            job_valid;
  logic            job_take;
  vp8df_pkg::job_t job;

  vp8df_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  vp8df_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/vp8df_parser.sv @@
`include "assert_macros.svh"

module vp8df_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vp8df_pkg::in_item_t in_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output logic                job_valid,
  output vp8df_pkg::job_t     job,
  input  logic                job_take
);

  logic [15:0] max_fragment_size;
  logic [vp8df_pkg::DESC_MAX-1:0][7:0] desc_store;
  logic [vp8df_pkg::DESC_MAX-1:0][7:0] desc_new;
  logic [2:0]  desc_length, desc_length_next;
  vp8df_pkg::phase_t phase, phase_next;
  logic [7:0]  ext_flags, ext_flags_next;
  logic [15:0] frag_count, frag_count_next;
  logic        first_frag, first_frag_next;
  logic [1:0]  payload_seen, payload_seen_next;
  logic [14:0] pid, pid_next;
  logic        key_flag, key_flag_next;
  vp8df_pkg::job_t job_next;
  logic        job_fire;
  logic        in_accept;

  logic [7:0]  b;
  logic        last;
  logic [15:0] room;
  logic [15:0] frag_inc;
  logic        frag_close;
  logic [7:0]  d0;
  logic        has_pid;
  vp8df_pkg::phase_t after_tl0, after_pid;

  assign in_ready  = !job_valid || job_take;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign b         = in_data.data_byte;
  assign last      = in_data.unit_last;

  // Hold the fragment size limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_fragment_size <= vp8df_pkg::MAX_FRAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_fragment_size <= cfg_data;
    end
  end

  // Parse one byte and build the replay job
  always_comb begin
    desc_new          = desc_store;
    desc_length_next  = desc_length;
    phase_next        = phase;
    ext_flags_next    = ext_flags;
    frag_count_next   = frag_count;
    first_frag_next   = first_frag;
    payload_seen_next = payload_seen;
    pid_next          = pid;
    key_flag_next     = key_flag;
    job_next          = '0;
    job_fire          = 1'b0;
    room              = 16'd1;
    frag_inc          = frag_count;
    frag_close        = 1'b0;
    after_tl0         = vp8df_pkg::PH_PAYLOAD;
    after_pid         = vp8df_pkg::PH_PAYLOAD;

    if (phase != vp8df_pkg::PH_PAYLOAD) begin
      // Store the descriptor byte
      for (int i = 0; i < vp8df_pkg::DESC_MAX; i++) begin
        if (desc_length == 3'(i)) begin
          desc_new[i] = b;
        end
      end
      if (desc_length < 3'(vp8df_pkg::DESC_MAX)) begin
        desc_length_next = desc_length + 3'd1;
      end
      if (phase == vp8df_pkg::PH_EXT) begin
        ext_flags_next = b;
      end
      after_tl0 = ((ext_flags_next & 8'h30) != 8'h00) ? vp8df_pkg::PH_TID
                                                       : vp8df_pkg::PH_PAYLOAD;
      after_pid = ((ext_flags_next & 8'h40) != 8'h00) ? vp8df_pkg::PH_TL0 : after_tl0;
      unique case (phase)
        vp8df_pkg::PH_FIRST: begin
          phase_next = ((b & vp8df_pkg::FLAG_X) != 8'h00) ? vp8df_pkg::PH_EXT
                                                          : vp8df_pkg::PH_PAYLOAD;
        end
        vp8df_pkg::PH_EXT: begin
          phase_next = ((b & vp8df_pkg::FLAG_X) != 8'h00) ? vp8df_pkg::PH_PID_HI
                                                          : after_pid;
        end
        vp8df_pkg::PH_PID_HI: begin
          pid_next   = {8'h00, b[6:0]};
          phase_next = ((b & vp8df_pkg::FLAG_X) != 8'h00) ? vp8df_pkg::PH_PID_LO
                                                          : after_pid;
        end
        vp8df_pkg::PH_PID_LO: begin
          pid_next   = {pid[6:0], b};
          phase_next = after_pid;
        end
        vp8df_pkg::PH_TL0: begin
          phase_next = after_tl0;
        end
        default: begin
          phase_next = vp8df_pkg::PH_PAYLOAD;
        end
      endcase
      // Unit ending inside the descriptor: replay it unchanged
      job_fire             = last;
      job_next.desc        = desc_new;
      job_next.desc_count  = desc_length_next;
      job_next.has_payload = 1'b0;
    end else begin
      // Payload byte: track key frame, count into the open fragment
      if (payload_seen == 2'd0) begin
        key_flag_next = ((b & vp8df_pkg::P_BIT) == 8'h00);
      end
      if (payload_seen != 2'd3) begin
        payload_seen_next = payload_seen + 2'd1;
      end
      room       = (max_fragment_size > {13'd0, desc_length})
                   ? max_fragment_size - {13'd0, desc_length} : 16'd1;
      frag_inc   = (frag_count != 16'hFFFF) ? frag_count + 16'd1 : frag_count;
      frag_close = last || (frag_inc >= room);
      frag_count_next = frag_close ? 16'd0 : frag_inc;
      first_frag_next = frag_close ? 1'b0 : first_frag;

      job_fire              = 1'b1;
      job_next.desc         = desc_store;
      if (!first_frag) begin
        job_next.desc[0] = desc_store[0] & ~vp8df_pkg::S_BIT;
      end
      job_next.desc_count   = (frag_count == 16'd0) ? desc_length : 3'd0;
      job_next.has_payload  = 1'b1;
      job_next.payload_byte = b;
      job_next.payload_last = frag_close;
    end

    // Report the unit summary and drop all unit state
    d0      = desc_new[0];
    has_pid = ((ext_flags_next & vp8df_pkg::FLAG_X) != 8'h00) && (desc_length_next >= 3'd3);
    if (last) begin
      job_next.unit_done      = 1'b1;
      job_next.has_picture_id = has_pid;
      job_next.picture_id     = has_pid ? pid_next : 15'd0;
      job_next.key_frame      = key_flag_next && (payload_seen_next == 2'd3)
                                && ((d0 & vp8df_pkg::S_BIT) != 8'h00) && (d0[2:0] == 3'd0);
      desc_length_next  = 3'd0;
      phase_next        = vp8df_pkg::PH_FIRST;
      ext_flags_next    = 8'h00;
      frag_count_next   = 16'd0;
      first_frag_next   = 1'b1;
      payload_seen_next = 2'd0;
      pid_next          = 15'd0;
      key_flag_next     = 1'b0;
    end
  end

  // Advance the unit state
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_length  <= 3'd0;
      phase        <= vp8df_pkg::PH_FIRST;
      ext_flags    <= 8'h00;
      frag_count   <= 16'd0;
      first_frag   <= 1'b1;
      payload_seen <= 2'd0;
      pid          <= 15'd0;
      key_flag     <= 1'b0;
    end else if (in_accept) begin
      desc_length  <= desc_length_next;
      phase        <= phase_next;
      ext_flags    <= ext_flags_next;
      frag_count   <= frag_count_next;
      first_frag   <= first_frag_next;
      payload_seen <= payload_seen_next;
      pid          <= pid_next;
      key_flag     <= key_flag_next;
    end
  end

  // Descriptor bytes, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      desc_store <= desc_new;
    end
  end

  // Job register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_accept) begin
      job_valid <= job_fire;
    end else if (job_take) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      job <= job_next;
    end
  end

  `ASSERT_CLK(a_payload_has_desc, clk, rst, phase == vp8df_pkg::PH_PAYLOAD |-> desc_length != 3'd0, "payload phase with empty descriptor")
  `ASSERT_CLK(a_unit_end_clears, clk, rst, (in_accept && in_data.unit_last) |=> (phase == vp8df_pkg::PH_FIRST && desc_length == 3'd0 && first_frag), "unit state not cleared at unit end")
  `ASSERT_NEVER(a_take_without_job, clk, rst, job_take && !job_valid, "job taken while none held")

endmodule

@@ rtl/core/vp8df_emitter.sv @@
`include "assert_macros.svh"

module vp8df_emitter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  vp8df_pkg::job_t      job,
  output logic                 job_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vp8df_pkg::out_item_t out_data
);

  logic [2:0] idx;
  logic [2:0] n;
  logic       elem_last;
  logic       in_desc;
  logic       out_load;
  logic [7:0] desc_byte;
  vp8df_pkg::out_item_t item;

  assign n         = job.desc_count + {2'b00, job.has_payload};
  assign elem_last = (idx == n - 3'd1);
  assign in_desc   = (idx < job.desc_count);
  assign out_load  = job_valid && (!out_valid || out_ready);
  assign job_take  = out_load && elem_last;

  // Select the result for the current position in the job
  always_comb begin
    desc_byte = 8'h00;
    for (int i = 0; i < vp8df_pkg::DESC_MAX; i++) begin
      if (idx == 3'(i)) begin
        desc_byte = job.desc[i];
      end
    end
    item                = '0;
    item.out_byte       = in_desc ? desc_byte : job.payload_byte;
    item.fragment_last  = in_desc ? (!job.has_payload && elem_last) : job.payload_last;
    if (elem_last && job.unit_done) begin
      item.unit_done      = 1'b1;
      item.has_picture_id = job.has_picture_id;
      item.picture_id     = job.picture_id;
      item.key_frame      = job.key_frame;
    end
  end

  // Advance through the job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (out_load) begin
      idx <= elem_last ? 3'd0 : idx + 3'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= item;
    end
  end

  `ASSERT_CLK(a_idle_idx, clk, rst, !job_valid |-> idx == 3'd0, "position counter not parked without a job")
  `ASSERT_CLK(a_idx_range, clk, rst, job_valid |-> idx < n, "position beyond end of job")
  `ASSERT_CLK(a_job_held, clk, rst, (out_load && !elem_last) |=> job_valid, "job dropped before its last result")

endmodule

@@ tb/vp8_descriptor_fragmenter_checker.sv @@
`timescale 1ns / 1ps

module vp8_descriptor_fragmenter_checker
  import vp8df_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  // Own copy of the fragmenter state
  logic [7:0]  desc_bytes [DESC_MAX];
  logic [2:0]  desc_len;
  phase_t      phase;
  logic [7:0]  ext_flags;
  logic [15:0] frag_fill;
  logic        first_frag;
  logic [1:0]  payload_tally;
  logic [14:0] pic_id;
  logic        p_clear;
  logic [15:0] frag_limit;

  // Fragment bytes still due from the block, oldest first
  out_item_t fragment_bytes_due [$];

  function automatic phase_t phase_after_tl0(input logic [7:0] ext);
    return (ext[5] || ext[4]) ? PH_TID : PH_PAYLOAD;
  endfunction

  function automatic phase_t phase_after_pid(input logic [7:0] ext);
    return ext[6] ? PH_TL0 : phase_after_tl0(ext);
  endfunction

  function automatic out_item_t plain_byte(input logic [7:0] b, input logic flast);
    out_item_t r;
    r = '0;
    r.out_byte = b;
    r.fragment_last = flast;
    return r;
  endfunction

  task automatic clear_unit_state();
    desc_len = '0;
    phase = PH_FIRST;
    ext_flags = '0;
    frag_fill = '0;
    first_frag = 1'b1;
    payload_tally = '0;
    pic_id = '0;
    p_clear = 1'b0;
  endtask

  // Work out every fragment byte that one input item releases
  task automatic fragment_byte(input in_item_t it);
    out_item_t   burst [7];
    int          n;
    int          i;
    logic [7:0]  b;
    logic [7:0]  d;
    logic [16:0] room;
    logic        flast;
    logic        has_pid;
    n = 0;
    b = it.data_byte;
    if (phase != PH_PAYLOAD) begin
      // Hold the descriptor byte and advance the parse
      if (desc_len < DESC_MAX) begin
        desc_bytes[desc_len] = b;
        desc_len++;
      end
      case (phase)
        PH_FIRST: begin
          phase = ((b & FLAG_X) != 0) ? PH_EXT : PH_PAYLOAD;
        end
        PH_EXT: begin
          ext_flags = b;
          phase = b[7] ? PH_PID_HI : phase_after_pid(b);
        end
        PH_PID_HI: begin
          pic_id = 15'(b & PID_MASK);
          phase = b[7] ? PH_PID_LO : phase_after_pid(ext_flags);
        end
        PH_PID_LO: begin
          pic_id = {pic_id[6:0], b};
          phase = phase_after_pid(ext_flags);
        end
        PH_TL0: begin
          phase = phase_after_tl0(ext_flags);
        end
        default: begin
          phase = PH_PAYLOAD;
        end
      endcase
      // Unit ends inside its descriptor: pass the held bytes through
      if (it.unit_last) begin
        for (i = 0; i < int'(desc_len); i++) begin
          burst[n] = plain_byte(desc_bytes[i], i == int'(desc_len) - 1);
          n++;
        end
      end
    end else begin
      room = (frag_limit > 16'(desc_len)) ? 17'(frag_limit) - 17'(desc_len) : 17'd1;
      if (payload_tally == 2'd0) p_clear = ((b & P_BIT) == 0);
      if (payload_tally < 2'd3) payload_tally++;
      // Open a fragment with a copy of the descriptor, S cleared after the first
      if (frag_fill == 16'd0) begin
        for (i = 0; i < int'(desc_len); i++) begin
          d = desc_bytes[i];
          if (i == 0 && !first_frag) d = d & ~S_BIT;
          burst[n] = plain_byte(d, 1'b0);
          n++;
        end
      end
      if (frag_fill != 16'hFFFF) frag_fill++;
      flast = it.unit_last || (17'(frag_fill) >= room);
      burst[n] = plain_byte(b, flast);
      n++;
      if (flast) begin
        frag_fill = '0;
        first_frag = 1'b0;
      end
    end
    // Tag the final byte of the unit with its summary
    if (it.unit_last && n > 0) begin
      has_pid = ext_flags[7] && (desc_len >= 3'd3);
      burst[n-1].unit_done = 1'b1;
      burst[n-1].has_picture_id = has_pid;
      burst[n-1].picture_id = has_pid ? pic_id : 15'd0;
      burst[n-1].key_frame = p_clear && (payload_tally == 2'd3) &&
                             ((desc_bytes[0] & S_BIT) != 0) && (desc_bytes[0][2:0] == 3'd0);
      clear_unit_state();
    end
    for (i = 0; i < n; i++) fragment_bytes_due = {fragment_bytes_due, burst[i]};
  endtask

  always @(posedge clk) begin
    out_item_t due;
    if (rst) begin
      clear_unit_state();
      frag_limit = MAX_FRAG_RESET;
      fragment_bytes_due.delete();
      fail_count = 0;
      checked = 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) frag_limit = cfg_data;
      if (in_valid && in_ready) fragment_byte(in_data);
      // Compare each delivered byte with the oldest one due
      if (out_valid && out_ready) begin
        if (fragment_bytes_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected item: expected none, actual byte %02h flast %b done %b",
                   $time, out_data.out_byte, out_data.fragment_last, out_data.unit_done);
        end else begin
          due = fragment_bytes_due.pop_front();
          checked++;
          if (out_data !== due) begin
            fail_count++;
            $display("%0t: mismatch: expected byte %02h flast %b done %b hpid %b pid %0d key %b",
                     $time, due.out_byte, due.fragment_last, due.unit_done,
                     due.has_picture_id, due.picture_id, due.key_frame);
            $display("%0t:          actual byte %02h flast %b done %b hpid %b pid %0d key %b",
                     $time, out_data.out_byte, out_data.fragment_last, out_data.unit_done,
                     out_data.has_picture_id, out_data.picture_id, out_data.key_frame);
          end
        end
      end
      pending <= fragment_bytes_due.size();
    end
  end

endmodule

@@ tb/vp8_descriptor_fragmenter_tb.sv @@
`timescale 1ns / 1ps

module vp8_descriptor_fragmenter_tb;
  import vp8df_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF       = 10;
  localparam int ITEM_TARGET    = 460;
  localparam int QUIET_FROM     = 400;

  typedef enum int {UNIT_FULL, UNIT_CUT, UNIT_NOISE} unit_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  in_item_t    in_data = '0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        cfg_ready;
  logic        out_valid;
  out_item_t   out_data;

  int fail_count;
  int pending;
  int checked;
  int bytes_sent = 0;
  int units_sent = 0;
  int limits_written = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int calm_left = 0;
  bit calm = 1'b0;
  bit quiet = 1'b0;
  bit gaps_on = 1'b1;

  always #5 clk = ~clk;

  vp8_descriptor_fragmenter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  vp8_descriptor_fragmenter_checker fragment_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // Stall the output side in short bursts, with calm stretches in between
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm_left = $urandom_range(30, 150);
      calm = ($urandom_range(0, 2) == 0);
    end else begin
      calm_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // End the run when no item moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, idle_cycles);
      $display("vp8_descriptor_fragmenter verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, unit_last: last};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Drop valid, wait for every due byte, then let the block drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limits_written++;
  endtask

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 11))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      4:       return MAX_FRAG_RESET;
      default: return 16'($urandom_range(2, 16));
    endcase
  endfunction

  // Build one unit (descriptor, payload) and stream it in
  task automatic send_unit(input unit_kind_t kind);
    logic [7:0] unit_q [$];
    logic [7:0] b0;
    logic [7:0] ext;
    logic [7:0] pid_hi;
    logic [7:0] pb;
    bit         make_key;
    int         desc_n;
    int         pay_len;
    int         split;
    int         i;
    b0 = 8'($urandom);
    make_key = ($urandom_range(0, 2) == 0);
    b0[7] = ($urandom_range(0, 4) != 0);
    if (make_key) begin
      b0[4] = 1'b1;
      b0[2:0] = 3'd0;
    end
    unit_q = {unit_q, b0};
    if (b0[7]) begin
      ext = 8'($urandom);
      unit_q = {unit_q, ext};
      if (ext[7]) begin
        pid_hi = 8'($urandom);
        unit_q = {unit_q, pid_hi};
        if (pid_hi[7]) unit_q = {unit_q, 8'($urandom)};
      end
      if (ext[6]) unit_q = {unit_q, 8'($urandom)};
      if (ext[5] || ext[4]) unit_q = {unit_q, 8'($urandom)};
    end
    desc_n = unit_q.size();
    pay_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24);
    for (i = 0; i < pay_len; i++) begin
      pb = 8'($urandom);
      if (i == 0 && make_key) pb[0] = 1'b0;
      unit_q = {unit_q, pb};
    end
    // Cut the unit inside its descriptor, or replace it with noise
    if (kind == UNIT_CUT) begin
      unit_q = unit_q[0 : $urandom_range(0, desc_n - 1)];
    end else if (kind == UNIT_NOISE) begin
      unit_q.delete();
      repeat ($urandom_range(1, 10)) unit_q = {unit_q, 8'($urandom)};
    end
    split = (kind == UNIT_FULL && $urandom_range(0, 9) == 0) ?
            $urandom_range(1, unit_q.size() - 1) : -1;
    for (i = 0; i < unit_q.size(); i++) begin
      if (i == split) write_limit(pick_limit());
      send_byte(unit_q[i], i == unit_q.size() - 1);
    end
    units_sent++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset limit, no extension, key frame
    send_byte(8'h10, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b1);
    // Unit ends inside a descriptor with a 15-bit picture ID
    send_byte(8'h90, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Single-byte unit
    send_byte(8'hFF, 1'b1);
    // Limit zero: descriptor not smaller than the limit
    write_limit(16'd0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    // Largest limit, five-byte descriptor with a 7-bit picture ID
    write_limit(16'hFFFF);
    send_byte(8'h90, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b1);
    // Limit lowered in the middle of an open fragment
    write_limit(MAX_FRAG_RESET);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    write_limit(16'd2);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h06, 1'b1);

    // Random phases: one limit each, a few units per phase
    while (bytes_sent < ITEM_TARGET) begin
      write_limit(pick_limit());
      repeat ($urandom_range(3, 6)) begin
        if (bytes_sent < ITEM_TARGET) begin
          if (bytes_sent >= QUIET_FROM) quiet = 1'b1;
          gaps_on = ($urandom_range(0, 2) != 0);
          case ($urandom_range(0, 9))
            0:       send_unit(UNIT_CUT);
            1:       send_unit(UNIT_NOISE);
            default: send_unit(UNIT_FULL);
          endcase
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Covered %0d input bytes in %0d units over %0d limit writes,", bytes_sent,
             units_sent, limits_written);
    $display("limits 0 to 65535 incl. mid-unit changes; %0d fragment bytes compared.", checked);
    if (pending != 0)
      $display("%0t: mismatch: expected %0d more fragment bytes, actual none", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("vp8_descriptor_fragmenter verification clean");
    end else begin
      $display("vp8_descriptor_fragmenter verification failed");
    end
    $finish;
  end

endmodule
